FILE: hdl/mi4_pkg.sv
package mi4_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 64;
  localparam int PROD_W    = 2 * ACC_W;
  localparam int HALF_W    = ACC_W / 2;
  localparam int DIV_STEPS = ACC_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int LANES     = 4;

  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_COF,
    ST_DET,
    ST_DIV,
    ST_RES,
    ST_OUT
  } state_t;

  // per-lane command: product step cycle, first term, subtract, negate
  typedef struct packed {
    logic       prod;
    logic [2:0] cyc;
    logic       first;
    logic       sub;
    logic       neg;
  } lane_cmd_t;

  localparam logic [2:0] CYC_ROUND = 3'd4;
  localparam logic [2:0] CYC_ACC   = 3'd5;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam acc_t WMAX_A  = (acc_t'(1) <<< (WORD_BITS-1)) - acc_t'(1);
  localparam acc_t WMIN_A  = -WMAX_A - acc_t'(1);

  function automatic acc_t sat_addsub(acc_t x, acc_t y, logic sub);
    acc_t s;
    logic ovf;
    s = sub ? x - y : x + y;
    if (sub) begin
      ovf = (x[ACC_W-1] != y[ACC_W-1]) && (s[ACC_W-1] != x[ACC_W-1]);
    end else begin
      ovf = (x[ACC_W-1] == y[ACC_W-1]) && (s[ACC_W-1] != x[ACC_W-1]);
    end
    if (ovf) begin
      s = x[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  function automatic acc_t sat_neg(acc_t x);
    return (x == ACC_MIN) ? ACC_MAX : -x;
  endfunction

  function automatic word_t sat_word(acc_t x);
    acc_t c;
    c = x;
    if (x > WMAX_A) begin
      c = WMAX_A;
    end else if (x < WMIN_A) begin
      c = WMIN_A;
    end
    return word_t'(c);
  endfunction

  // column pair of each 2x2 minor; the two spare codes are never written back
  function automatic logic [1:0] min_col_a(logic [2:0] j);
    logic [1:0] c;
    case (j)
      3'd0, 3'd1, 3'd2: c = 2'd0;
      3'd3, 3'd4:       c = 2'd1;
      3'd5:             c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] min_col_b(logic [2:0] j);
    logic [1:0] c;
    case (j)
      3'd0:       c = 2'd1;
      3'd1, 3'd3: c = 2'd2;
      3'd2, 3'd4, 3'd5: c = 2'd3;
      default:    c = 2'd1;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] set_row_p(logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : 2'd1;
  endfunction

  function automatic logic [1:0] set_row_q(logic [1:0] s);
    return (s == 2'd2) ? 2'd2 : 2'd3;
  endfunction

  // minor used by term t of cofactor row r
  function automatic logic [2:0] cof_v(logic [1:0] r, logic [1:0] t);
    logic [2:0] v;
    case ({r, t})
      4'b00_00: v = 3'd5;
      4'b00_01: v = 3'd4;
      4'b00_10: v = 3'd3;
      4'b01_00: v = 3'd5;
      4'b01_01: v = 3'd2;
      4'b01_10: v = 3'd1;
      4'b10_00: v = 3'd4;
      4'b10_01: v = 3'd2;
      4'b10_10: v = 3'd0;
      4'b11_00: v = 3'd3;
      4'b11_01: v = 3'd1;
      4'b11_10: v = 3'd0;
      default:  v = 3'd0;
    endcase
    return v;
  endfunction

  // column of the x row used by term t of cofactor row r
  function automatic logic [1:0] cof_x(logic [1:0] r, logic [1:0] t);
    logic [1:0] x;
    case ({r, t})
      4'b00_00: x = 2'd1;
      4'b00_01: x = 2'd2;
      4'b00_10: x = 2'd3;
      4'b01_00: x = 2'd0;
      4'b01_01: x = 2'd2;
      4'b01_10: x = 2'd3;
      4'b10_00: x = 2'd0;
      4'b10_01: x = 2'd1;
      4'b10_10: x = 2'd3;
      4'b11_00: x = 2'd0;
      4'b11_01: x = 2'd1;
      4'b11_10: x = 2'd2;
      default:  x = 2'd0;
    endcase
    return x;
  endfunction

endpackage

FILE: hdl/matrix4x4_inverse.sv
// 4x4 matrix inverse by cofactors, signed Q16.16. The matrix arrives as four
// requests, one column each (first_column restarts at column 0). Columns 0..2
// are taken one a cycle and produce nothing; column 3 starts the solve, and
// the next request is taken only after all four inverse columns have gone
// out. The work runs on four shared multiply lanes (each Q product is built
// from 32x32 partial products): the 2x2 minors, the cofactors, the
// determinant, then the bit-serial reciprocal and, per output column,
// forming the column and handing it over when it is taken.
// A zero determinant or an out-of-range reciprocal raises singular with all
// rows zero.
module matrix4x4_inverse import mi4_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  first_column,
  input  word_t elem_row0,
  input  word_t elem_row1,
  input  word_t elem_row2,
  input  word_t elem_row3,
  output logic  out_valid,
  input  logic  out_stall,
  output logic [1:0] out_column,
  output word_t inv_row0,
  output word_t inv_row1,
  output word_t inv_row2,
  output word_t inv_row3,
  output logic  singular,
  output logic  last
);

  state_t     state;
  state_t     state_next;
  logic [1:0] column_count;
  logic [1:0] col_in;
  logic       in_acc;
  logic       out_acc;

  word_t store [4][4];

  logic [2:0] step;
  logic [2:0] cyc;
  logic [2:0] nprod;
  logic [2:0] last_step;
  logic       prod_step;
  logic       step_done;
  logic       phase_end;
  logic [1:0] set_idx;
  logic       rnd;
  logic [1:0] col_k;

  acc_t v [6];
  acc_t cof [4][4];
  acc_t det;
  acc_t inv;
  logic sing;

  lane_cmd_t cmd [LANES];
  acc_t      op_a [LANES];
  acc_t      op_b [LANES];
  acc_t      lane_acc [LANES];

  logic             div_start;
  logic             div_done;
  logic [ACC_W-1:0] div_dm;
  logic [ACC_W-1:0] div_q;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign col_in   = first_column ? 2'd0 : column_count;

  always_comb begin
    case (state)
      ST_MIN: begin
        nprod = 3'd2; last_step = 3'd2;
      end
      ST_COF: begin
        nprod = 3'd3; last_step = 3'd4;
      end
      ST_DET: begin
        nprod = 3'd4; last_step = 3'd4;
      end
      ST_RES: begin
        nprod = 3'd1; last_step = 3'd1;
      end
      default: begin
        nprod = 3'd0; last_step = 3'd0;
      end
    endcase
  end

  assign prod_step = step < nprod;
  assign step_done = prod_step ? (cyc == CYC_ACC) : 1'b1;
  assign phase_end = step_done && (step == last_step);

  assign div_start = (state == ST_DET) && phase_end && (lane_acc[0] != acc_t'(0));
  assign div_dm    = lane_acc[0][ACC_W-1] ? ACC_W'(-lane_acc[0]) : ACC_W'(lane_acc[0]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && col_in == 2'd3) state_next = ST_MIN;
      ST_MIN:  if (phase_end && rnd) state_next = ST_COF;
      ST_COF: begin
        if (phase_end) begin
          if (col_k == 2'd3) begin
            state_next = ST_DET;
          end else if (col_k != 2'd0) begin
            state_next = ST_MIN;
          end
        end
      end
      ST_DET: if (phase_end) state_next = (lane_acc[0] == acc_t'(0)) ? ST_RES : ST_DIV;
      ST_DIV: if (div_done) state_next = ST_RES;
      ST_RES: if (phase_end) state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = (col_k == 2'd3) ? ST_IDLE : ST_RES;
      default: state_next = ST_IDLE;
    endcase
  end

  // lane commands and operand selection
  always_comb begin
    logic [2:0] j;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] prow;
    logic [1:0] qrow;
    logic [2:0] vi;
    logic [1:0] xi;
    logic [1:0] xrow;
    logic [1:0] li;
    for (int l = 0; l < LANES; l++) begin
      li   = 2'(l);
      j    = {rnd, li};
      ca   = min_col_a(j);
      cb   = min_col_b(j);
      prow = set_row_p(set_idx);
      qrow = set_row_q(set_idx);
      vi   = cof_v(li, step[1:0]);
      xi   = cof_x(li, step[1:0]);
      xrow = (col_k == 2'd0) ? 2'd1 : 2'd0;
      cmd[l].prod  = prod_step;
      cmd[l].cyc   = cyc;
      cmd[l].first = (step == 3'd0);
      cmd[l].sub   = 1'b0;
      cmd[l].neg   = 1'b0;
      op_a[l]      = '0;
      op_b[l]      = '0;
      case (state)
        ST_MIN: begin
          cmd[l].sub = (step != 3'd0);
          if (step == 3'd0) begin
            op_a[l] = acc_t'(store[ca][prow]);
            op_b[l] = acc_t'(store[cb][qrow]);
          end else begin
            op_a[l] = acc_t'(store[cb][prow]);
            op_b[l] = acc_t'(store[ca][qrow]);
          end
        end
        ST_COF: begin
          cmd[l].sub = (step == 3'd1);
          cmd[l].neg = (step == 3'd3) && (li[0] ^ col_k[0]);
          op_a[l]    = v[vi];
          op_b[l]    = acc_t'(store[xi][xrow]);
        end
        ST_DET: begin
          op_a[l] = cof[0][step[1:0]];
          op_b[l] = acc_t'(store[step[1:0]][0]);
        end
        ST_RES: begin
          op_a[l] = cof[col_k][li];
          op_b[l] = inv;
        end
        default: begin
          op_a[l] = '0;
        end
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mi4_lane u_lane (
      .clk (clk),
      .cmd (cmd[g]),
      .a   (op_a[g]),
      .b   (op_b[g]),
      .acc (lane_acc[g])
    );
  end

  mi4_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dm    (div_dm),
    .done  (div_done),
    .quot  (div_q)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      step         <= '0;
      cyc          <= '0;
      set_idx      <= '0;
      rnd          <= 1'b0;
      col_k        <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state || phase_end) begin
        step <= '0;
        cyc  <= '0;
      end else if (step_done) begin
        step <= step + 1'b1;
        cyc  <= '0;
      end else begin
        cyc <= cyc + 1'b1;
      end

      if (in_acc) begin
        column_count <= col_in + 1'b1;
        set_idx      <= '0;
        rnd          <= 1'b0;
        col_k        <= '0;
      end

      if (state == ST_MIN && phase_end) begin
        if (!rnd) begin
          rnd <= 1'b1;
        end else begin
          rnd   <= 1'b0;
          col_k <= (set_idx == 2'd0) ? 2'd0 : set_idx + 1'b1;
        end
      end

      if (state == ST_COF && phase_end) begin
        if (col_k == 2'd0) begin
          col_k <= 2'd1;
        end else if (col_k != 2'd3) begin
          set_idx <= set_idx + 1'b1;
        end
      end

      if (state == ST_DET && phase_end) begin
        col_k <= '0;
      end

      if (state == ST_RES && phase_end) begin
        out_valid <= 1'b1;
      end

      if (out_acc) begin
        out_valid <= 1'b0;
        if (col_k != 2'd3) begin
          col_k <= col_k + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      store[col_in][0] <= elem_row0;
      store[col_in][1] <= elem_row1;
      store[col_in][2] <= elem_row2;
      store[col_in][3] <= elem_row3;
    end

    if (state == ST_MIN && phase_end) begin
      for (int l = 0; l < LANES; l++) begin
        if ({rnd, 2'(l)} < 3'd6) begin
          v[{rnd, 2'(l)}] <= lane_acc[l];
        end
      end
    end

    if (state == ST_COF && phase_end) begin
      for (int l = 0; l < LANES; l++) begin
        cof[col_k][l] <= lane_acc[l];
      end
    end

    if (state == ST_DET && phase_end) begin
      det  <= lane_acc[0];
      sing <= (lane_acc[0] == acc_t'(0));
      inv  <= '0;
    end

    if (state == ST_DIV && div_done) begin
      if (div_q > ACC_W'(WMAX_A)) begin
        sing <= 1'b1;
      end else begin
        inv <= det[ACC_W-1] ? acc_t'(-div_q) : acc_t'(div_q);
      end
    end

    if (state == ST_RES && phase_end) begin
      out_column <= col_k;
      singular   <= sing;
      last       <= (col_k == 2'd3);
      inv_row0   <= sing ? word_t'(0) : sat_word(lane_acc[0]);
      inv_row1   <= sing ? word_t'(0) : sat_word(lane_acc[1]);
      inv_row2   <= sing ? word_t'(0) : sat_word(lane_acc[2]);
      inv_row3   <= sing ? word_t'(0) : sat_word(lane_acc[3]);
    end
  end

endmodule

FILE: hdl/mi4_lane.sv
module mi4_lane import mi4_pkg::*; (
  input  logic      clk,
  input  lane_cmd_t cmd,
  input  acc_t      a,
  input  acc_t      b,
  output acc_t      acc
);

  logic [ACC_W-1:0]    amag;
  logic [ACC_W-1:0]    bmag;
  logic [HALF_W-1:0]   ah;
  logic [HALF_W-1:0]   bh;
  logic [2*HALF_W-1:0] part;
  logic [PROD_W-1:0]   part_sh;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   rsum;
  logic [PROD_W-1:0]   rshift;
  logic [ACC_W-1:0]    rlo;
  logic                pneg;
  acc_t                rnd_val;
  acc_t                pr;
  acc_t                base;

  assign amag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
  assign bmag = b[ACC_W-1] ? ACC_W'(-b) : ACC_W'(b);
  assign ah   = cmd.cyc[1] ? amag[ACC_W-1:HALF_W] : amag[HALF_W-1:0];
  assign bh   = cmd.cyc[0] ? bmag[ACC_W-1:HALF_W] : bmag[HALF_W-1:0];
  assign part = ah * bh;

  // one 32x32 partial product per cycle, weighted by its half indexes
  assign part_sh = {{(PROD_W-2*HALF_W){1'b0}}, part}
                   << {cmd.cyc[1] & cmd.cyc[0], cmd.cyc[1] ^ cmd.cyc[0], 5'b0};

  // round half away from zero on the magnitude, then saturate
  assign rsum   = prod + (PROD_W'(1) << (FRAC_BITS-1));
  assign rshift = rsum >> FRAC_BITS;
  assign rlo    = (|rshift[PROD_W-1:ACC_W]) ? {ACC_W{1'b1}} : rshift[ACC_W-1:0];
  assign pneg   = a[ACC_W-1] ^ b[ACC_W-1];

  always_comb begin
    if (pneg) begin
      rnd_val = rlo[ACC_W-1] ? ACC_MIN : acc_t'(-rlo);
    end else begin
      rnd_val = rlo[ACC_W-1] ? ACC_MAX : acc_t'(rlo);
    end
  end

  assign base = cmd.first ? acc_t'(0) : acc;

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      if (cmd.cyc == CYC_ROUND) begin
        pr <= rnd_val;
      end else if (cmd.cyc == CYC_ACC) begin
        acc <= sat_addsub(base, pr, cmd.sub);
      end else begin
        prod <= ((cmd.cyc == 3'd0) ? {PROD_W{1'b0}} : prod) + part_sh;
      end
    end else if (cmd.neg) begin
      acc <= sat_neg(acc);
    end
  end

endmodule

FILE: hdl/mi4_div.sv
module mi4_div import mi4_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dm,
  output logic             done,
  output logic [ACC_W-1:0] quot
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [ACC_W:0]    rem;
  logic [ACC_W-1:0]  dvs;
  logic [ACC_W:0]    shifted;
  logic              fits;

  assign shifted = {rem[ACC_W-1:0], quot[ACC_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DCNT_W'(DIV_STEPS-1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS-1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= dm;
      rem  <= '0;
      quot <= (ACC_W'(1) << (2*FRAC_BITS)) + (dm >> 1);
    end else if (busy) begin
      rem  <= fits ? shifted - {1'b0, dvs} : shifted;
      quot <= {quot[ACC_W-2:0], fits};
    end
  end

endmodule

FILE: sim/matrix4x4_inverse_test.sv
`timescale 1ns / 100ps

module matrix4x4_inverse_test import mi4_pkg::*; ();

  typedef struct {
    logic [1:0] col;
    word_t      rows[4];
    logic       sing;
    logic       lst;
  } inv_col_t;

  logic clk, rst;
  logic in_valid, in_stall, first_column;
  word_t elem_row0, elem_row1, elem_row2, elem_row3;
  logic out_valid, out_stall;
  logic [1:0] out_column;
  word_t inv_row0, inv_row1, inv_row2, inv_row3;
  logic singular, last;

  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_recv = 0;
  bit sending_done = 0;
  int idle_sets[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{33, 33}};

  matrix4x4_inverse dut (.*);

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // 64-bit saturating helpers
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(Q_MAX)) return Q_MAX;
    if (s < 65'(Q_MIN)) return Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(Q_MAX)) return Q_MAX;
    if (s < 65'(Q_MIN)) return Q_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_neg(logic signed [63:0] a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0] ua, ub, m;
    logic [128:0] p;
    bit neg;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    neg = a[63] != b[63];
    p = (129'(ua) * 129'(ub) + (129'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    m = (p[128:64] != 0) ? '1 : p[63:0];
    if (neg) return (m >= 64'h8000_0000_0000_0000) ? Q_MIN : -$signed(m);
    return (m > 64'h7FFF_FFFF_FFFF_FFFF) ? Q_MAX : $signed(m);
  endfunction

  class inverse_scoreboard;
    logic signed [63:0] mstore[4][4]; // [row][col]
    logic [1:0] next_col = 0;
    inv_col_t pending[$];

    function void minors6(int p, int q, output logic signed [63:0] v[6]);
      int ca[6] = '{0, 0, 0, 1, 1, 2};
      int cb[6] = '{1, 2, 3, 2, 3, 3};
      for (int j = 0; j < 6; j++)
        v[j] = q_sub(q_mul(mstore[p][ca[j]], mstore[q][cb[j]]),
                     q_mul(mstore[p][cb[j]], mstore[q][ca[j]]));
    endfunction

    function void cofs(logic signed [63:0] v[6], int xr, int k,
                       ref logic signed [63:0] e[4][4]);
      int vi[4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};
      int xi[4][3] = '{'{1, 2, 3}, '{0, 2, 3}, '{0, 1, 3}, '{0, 1, 2}};
      for (int r = 0; r < 4; r++) begin
        e[k][r] = q_add(q_sub(q_mul(v[vi[r][0]], mstore[xr][xi[r][0]]),
                              q_mul(v[vi[r][1]], mstore[xr][xi[r][1]])),
                        q_mul(v[vi[r][2]], mstore[xr][xi[r][2]]));
        if (((r + k) & 1) != 0) e[k][r] = q_neg(e[k][r]);
      end
    endfunction

    function void note_column(logic fc, word_t e[4]);
      logic [1:0] c;
      logic signed [63:0] v[6], cf[4][4], det, rcp, d;
      logic [63:0] dm, qq;
      bit sing;
      inv_col_t o;
      c = fc ? 2'd0 : next_col;
      for (int r = 0; r < 4; r++) mstore[r][c] = e[r];
      next_col = c + 2'd1;
      if (c != 2'd3) return;
      minors6(2, 3, v);
      cofs(v, 1, 0, cf);
      cofs(v, 0, 1, cf);
      minors6(1, 3, v);
      cofs(v, 0, 2, cf);
      minors6(1, 2, v);
      cofs(v, 0, 3, cf);
      det = q_mul(cf[0][0], mstore[0][0]);
      for (int k = 1; k < 4; k++) det = q_add(det, q_mul(cf[0][k], mstore[0][k]));
      sing = (det == 0);
      rcp = 0;
      if (!sing) begin
        dm = det[63] ? -det : det;
        qq = ((64'd1 << (2 * FRAC_BITS)) + dm / 2) / dm;
        if (qq > 64'h7FFF_FFFF) sing = 1;
        else rcp = det[63] ? -$signed(qq) : $signed(qq);
      end
      for (int k = 0; k < 4; k++) begin
        o.col = 2'(k);
        for (int r = 0; r < 4; r++) begin
          d = q_mul(cf[k][r], rcp);
          if (sing) o.rows[r] = '0;
          else if (d > 64'sh7FFF_FFFF) o.rows[r] = 32'h7FFF_FFFF;
          else if (d < -64'sh8000_0000) o.rows[r] = 32'h8000_0000;
          else o.rows[r] = d[31:0];
        end
        o.sing = sing;
        o.lst = (k == 3);
        pending.push_back(o);
      end
    endfunction

    task check_column(inv_col_t got);
      inv_col_t x;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result column %0d", got.col));
        return;
      end
      x = pending.pop_front();
      if (got.col !== x.col) report($sformatf("out_column %0d exp %0d", got.col, x.col));
      for (int r = 0; r < 4; r++)
        if (got.rows[r] !== x.rows[r])
          report($sformatf("col %0d row %0d got %h exp %h", x.col, r, got.rows[r], x.rows[r]));
      if (got.sing !== x.sing) report($sformatf("singular %b exp %b", got.sing, x.sing));
      if (got.lst !== x.lst) report($sformatf("last %b exp %b", got.lst, x.lst));
    endtask
  endclass

  inverse_scoreboard sb = new();

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("matrix4x4_inverse_test NOT OK");
    $finish;
  end

  // one request; idles before it by the current sender percentage
  task automatic send_column(logic fc, word_t e0, word_t e1, word_t e2, word_t e3);
    word_t e[4];
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    first_column <= fc;
    elem_row0 <= e0; elem_row1 <= e1; elem_row2 <= e2; elem_row3 <= e3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = '{e0, e1, e2, e3};
    sb.note_column(fc, e);
    @(negedge clk);
  endtask

  function automatic word_t rand_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
      2: return $signed($urandom_range(0, 4)) - 2 <<< FRAC_BITS;
      default: return $signed($urandom_range(0, 1 << 12)) - (1 << 11);
    endcase
  endfunction

  task automatic send_matrix(int kind);
    for (int c = 0; c < 4; c++)
      send_column(c == 0, rand_elem(kind), rand_elem(kind), rand_elem(kind), rand_elem(kind));
  endtask

  // identity scaled by s on the diagonal
  task automatic send_diag(word_t s);
    send_column(1, s, 0, 0, 0);
    send_column(0, 0, s, 0, 0);
    send_column(0, 0, 0, s, 0);
    send_column(0, 0, 0, 0, s);
  endtask

  // output side
  always @(posedge clk) begin
    inv_col_t g;
    if (!rst && out_valid && !out_stall) begin
      g.col = out_column;
      g.rows = '{inv_row0, inv_row1, inv_row2, inv_row3};
      g.sing = singular;
      g.lst = last;
      sb.check_column(g);
    end
  end

  always @(negedge clk)
    out_stall <= hold_recv || ($urandom_range(99) < recv_stall);

  // long receiver hold-off while the sender keeps going
  initial begin
    wait (sending_done == 0 && rst == 0);
    wait (send_idle == 1);
    hold_recv = 1;
    repeat (800) @(negedge clk);
    hold_recv = 0;
  end

  initial begin
    rst = 1;
    in_valid = 0; first_column = 0;
    elem_row0 = 0; elem_row1 = 0; elem_row2 = 0; elem_row3 = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed
    send_diag(32'h0001_0000);
    send_diag(32'h0002_0000);
    send_diag(32'h0000_0000);                  // zero determinant
    send_diag(32'h0000_1000);                  // reciprocal overflow
    send_diag(32'h7FFF_FFFF);                  // reciprocal underflow / saturation
    send_column(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_column(0, 1, 2, 3, 4);
    send_column(1, 32'h0001_0000, 0, 0, 0);     // restart mid-matrix
    send_column(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_column(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
    send_column(0, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000);
    send_column(0, 5, 6, 7, 8);                 // wraps to column 0, no result

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 1 : idle_sets[ph][0];
      recv_stall = idle_sets[ph][1];
      for (int n = 0; n < 22; n++) begin
        if (ph == 1 && n == 3) send_idle = idle_sets[ph][0];
        if ($urandom_range(9) == 0)
          send_column($urandom_range(1), rand_elem(0), rand_elem(1), rand_elem(2), rand_elem(3));
        else
          send_matrix($urandom_range(3));
      end
    end
    in_valid <= 0;
    sending_done = 1;
    recv_stall = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("matrix4x4_inverse_test OK");
    else
      $display("matrix4x4_inverse_test NOT OK");
    $finish;
  end
endmodule

FILE: files.f
hdl/mi4_pkg.sv
hdl/mi4_lane.sv
hdl/mi4_div.sv
hdl/matrix4x4_inverse.sv
sim/matrix4x4_inverse_test.sv
